>>> src/sll_pkg.sv
package sll_pkg;

    // Built size of the list and width of a stored element
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Field widths of requests and results
    localparam int OP_W  = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;
    localparam int CAP_W = 5;

    // Reset value of the usable-slot register
    localparam int CAP_RESET = 16;

    // Internal widths derived from the built size
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SLOT_W = CNT_W;
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Stream word widths, padded to whole bytes
    localparam int IN_W  = ((OP_W + POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_W = ((ST_W + VAL_W + LEN_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_APPLY = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        cell_cmd_t              cmd;
        logic [CNT_W-1:0]       pos;
        logic [DATA_WIDTH-1:0]  value;
        logic [SLOT_W-1:0]      slot;
    } cell_ctl_t;

    // One finished result
    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   value;
        logic [LEN_W-1:0]   length;
    } result_t;

endpackage

>>> src/sll_cell.sv
module sll_cell (
    input  logic                           clk,
    input  sll_pkg::cell_ctl_t             ctl,
    input  logic [sll_pkg::CNT_W-1:0]      cell_idx,
    input  logic [sll_pkg::DATA_WIDTH-1:0] left_value,
    input  logic [sll_pkg::SLOT_W-1:0]     left_slot,
    input  logic [sll_pkg::DATA_WIDTH-1:0] right_value,
    input  logic [sll_pkg::SLOT_W-1:0]     right_slot,
    output logic [sll_pkg::DATA_WIDTH-1:0] value,
    output logic [sll_pkg::SLOT_W-1:0]     slot
);
    import sll_pkg::*;

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;

    // Shift toward the tail on insert, toward the head on delete
    always_comb
    begin
        value_next = value_reg;
        slot_next  = slot_reg;
        unique case (ctl.cmd)
            CELL_INSERT:
            begin
                if (cell_idx > ctl.pos)
                begin
                    value_next = left_value;
                    slot_next  = left_slot;
                end
                else if (cell_idx == ctl.pos)
                begin
                    value_next = ctl.value;
                    slot_next  = ctl.slot;
                end
            end
            CELL_DELETE:
            begin
                if (cell_idx >= ctl.pos)
                begin
                    value_next = right_value;
                    slot_next  = right_slot;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold element payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        slot_reg  <= slot_next;
    end

    assign value = value_reg;
    assign slot  = slot_reg;

endmodule

>>> src/sll_ctrl.sv
module sll_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sll_pkg::opcode_t               in_op,
    input  logic [sll_pkg::POS_W-1:0]      in_pos,
    input  logic [sll_pkg::VAL_W-1:0]      in_value,
    input  logic                           cfg_wr_en,
    input  logic [sll_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic                           out_free,
    output logic                           res_push,
    output sll_pkg::result_t               result,
    output sll_pkg::cell_ctl_t             cell_ctl,
    input  logic [sll_pkg::DATA_WIDTH-1:0] rd_value,
    input  logic [sll_pkg::SLOT_W-1:0]     rd_slot
);
    import sll_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    opcode_t               op_reg;
    opcode_t               op_next;
    logic [CNT_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      pos_next;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic [SLOT_W-1:0]     scan_reg;
    logic [SLOT_W-1:0]     scan_next;
    logic [CAPACITY:1]     busy_reg;
    logic [CAPACITY:1]     busy_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CAP_W-1:0]      cap_reg;
    status_t               status_reg;
    status_t               status_next;
    logic [VAL_W-1:0]      res_value_reg;
    logic [VAL_W-1:0]      res_value_next;

    logic                  in_accept;
    logic [CNT_W-1:0]      cap_eff;
    logic                  has_room;
    logic                  pos_bad;
    logic                  slot_free;
    logic                  scan_last;

    // Saturate the usable slot count at the built size
    assign cap_eff = (CMP_W'(cap_reg) > CMP_W'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                          : CNT_W'(cap_reg);
    assign has_room  = count_reg < cap_eff;
    assign pos_bad   = CMP_W'(in_pos) >= CMP_W'(count_reg);
    assign slot_free = !busy_reg[scan_reg];
    assign scan_last = scan_reg == cap_eff;
    assign in_accept = in_valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_op) inside
                        OP_INSERT:            state_next = has_room ? ST_SCAN : ST_DONE;
                        OP_GET, OP_DELETE:    state_next = pos_bad ? ST_DONE : ST_APPLY;
                        default:              state_next = ST_APPLY;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (slot_free)
                begin
                    state_next = ST_APPLY;
                end
                else if (scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and cell command
    always_comb
    begin
        in_ready       = 1'b0;
        res_push       = 1'b0;
        cell_ctl.cmd   = CELL_HOLD;
        cell_ctl.pos   = pos_reg;
        cell_ctl.value = value_reg;
        cell_ctl.slot  = scan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_APPLY:
            begin
                if (op_reg == OP_INSERT)
                begin
                    cell_ctl.cmd = CELL_INSERT;
                end
                else if (op_reg == OP_DELETE)
                begin
                    cell_ctl.cmd = CELL_DELETE;
                end
            end
            ST_DONE:
            begin
                res_push = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign result.status = status_reg;
    assign result.value  = res_value_reg;
    assign result.length = LEN_W'(count_reg);

    // Request capture, slot scan and list bookkeeping
    always_comb
    begin
        op_next        = op_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        scan_next      = scan_reg;
        busy_next      = busy_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        res_value_next = res_value_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next        = in_op;
                    value_next     = DATA_WIDTH'(in_value);
                    scan_next      = SLOT_W'(1);
                    res_value_next = '0;
                    status_next    = STAT_OK;
                    // clamp an insert past the end to an append
                    if (CMP_W'(in_pos) > CMP_W'(count_reg))
                    begin
                        pos_next = count_reg;
                    end
                    else
                    begin
                        pos_next = CNT_W'(in_pos);
                    end
                    if (in_op == OP_INSERT && !has_room)
                    begin
                        status_next = STAT_FULL;
                    end
                    else if ((in_op == OP_GET || in_op == OP_DELETE) && pos_bad)
                    begin
                        status_next = STAT_RANGE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!slot_free)
                begin
                    if (scan_last)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        scan_next = scan_reg + SLOT_W'(1);
                    end
                end
            end
            ST_APPLY:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        busy_next[scan_reg] = 1'b1;
                        count_next          = count_reg + CNT_W'(1);
                    end
                    OP_GET:
                    begin
                        res_value_next = VAL_W'(rd_value);
                    end
                    OP_DELETE:
                    begin
                        res_value_next     = VAL_W'(rd_value);
                        busy_next[rd_slot] = 1'b0;
                        count_next         = count_reg - CNT_W'(1);
                    end
                    default:
                    begin
                        busy_next  = '0;
                        count_next = '0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_W'(CAP_RESET);
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Request payload and result
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        value_reg     <= value_next;
        scan_reg      <= scan_next;
        status_reg    <= status_next;
        res_value_reg <= res_value_next;
    end

    // Busy map and length agree
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_reg) == int'(count_reg))
        else $error("busy slot count differs from list length");

    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("list length beyond built capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && op_reg == OP_INSERT) |-> !busy_reg[scan_reg])
        else $error("insert into a busy slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && op_reg == OP_DELETE) |-> busy_reg[rd_slot])
        else $error("delete of a slot that is not busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != ST_IDLE)
        else $error("accepted request left no work");

endmodule

>>> src/static_linked_list_engine_top.sv
// Fixed-capacity linked list. Each request on the input stream (insert, get,
// delete or clear) yields exactly one result carrying a status, the value read
// or removed, and the list length afterwards. Elements sit in a chain of cells
// in list order, each tagged with the slot it occupies; a busy map tracks the
// slots. Insert scans the busy map one slot per cycle from slot 1 for the
// lowest free usable slot. One request is in work at a time; a finished
// result waits in the output register while the next request is taken. The
// user must write the usable slot count over cfg_wr_en and cfg_wr_data only
// while the block is idle; the block itself does not enforce this. Values
// above the built capacity act as the built capacity.
module static_linked_list_engine_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // opcode [1:0], position [6:2], value_in [38:7], zero pad above
    input  logic [sll_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // status [1:0], value_out [33:2], list_length [38:34], zero pad above
    output logic [sll_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                      cfg_wr_en,
    input  logic [sll_pkg::CAP_W-1:0] cfg_wr_data
);
    import sll_pkg::*;

    opcode_t               in_op;
    logic [POS_W-1:0]      in_pos;
    logic [VAL_W-1:0]      in_value;
    logic                  out_free;
    logic                  res_push;
    result_t               result;
    cell_ctl_t             cell_ctl;
    logic [DATA_WIDTH-1:0] rd_value;
    logic [SLOT_W-1:0]     rd_slot;

    logic [DATA_WIDTH-1:0] cell_value [CAPACITY];
    logic [SLOT_W-1:0]     cell_slot  [CAPACITY];
    logic [DATA_WIDTH-1:0] left_value [CAPACITY];
    logic [SLOT_W-1:0]     left_slot  [CAPACITY];
    logic [DATA_WIDTH-1:0] right_value[CAPACITY];
    logic [SLOT_W-1:0]     right_slot [CAPACITY];

    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_data_reg;

    // Unpack the request
    assign in_op    = opcode_t'(s_axis_tdata[OP_W-1:0]);
    assign in_pos   = s_axis_tdata[OP_W +: POS_W];
    assign in_value = s_axis_tdata[OP_W + POS_W +: VAL_W];

    sll_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (in_op),
        .in_pos      (in_pos),
        .in_value    (in_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_free    (out_free),
        .res_push    (res_push),
        .result      (result),
        .cell_ctl    (cell_ctl),
        .rd_value    (rd_value),
        .rd_slot     (rd_slot)
    );

    // Chain of element cells in list order
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        if (gi == 0)
        begin : g_head
            assign left_value[gi] = '0;
            assign left_slot[gi]  = '0;
        end
        else
        begin : g_left
            assign left_value[gi] = cell_value[gi-1];
            assign left_slot[gi]  = cell_slot[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_tail
            assign right_value[gi] = '0;
            assign right_slot[gi]  = '0;
        end
        else
        begin : g_right
            assign right_value[gi] = cell_value[gi+1];
            assign right_slot[gi]  = cell_slot[gi+1];
        end

        sll_cell u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .cell_idx    (CNT_W'(gi)),
            .left_value  (left_value[gi]),
            .left_slot   (left_slot[gi]),
            .right_value (right_value[gi]),
            .right_slot  (right_slot[gi]),
            .value       (cell_value[gi]),
            .slot        (cell_slot[gi])
        );
    end

    // Read the element at the requested position
    assign rd_value = cell_value[cell_ctl.pos[IDX_W-1:0]];
    assign rd_slot  = cell_slot[cell_ctl.pos[IDX_W-1:0]];

    // Output register: load a result when empty or being drained
    assign out_free       = !out_valid_reg || m_axis_tready;
    assign out_valid_next = res_push || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_data_reg.length, out_data_reg.value,
                                   out_data_reg.status});

endmodule
